FILE: hw/rtl/teoq_pkg.sv
// Shared types, codes and sizes for the tick-ordered event queue.
// No dependencies; every other file refers to it by scoped name.
`default_nettype none
package teoq_pkg;

	localparam int TICK_W      = 32;
	localparam int HANDLE_W    = 8;
	localparam int COUNT_OUT_W = 7;
	localparam int DEPTH_DEF   = 64;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_NOP    = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2,
		ST_RSVD = 2'd3
	} status_code_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_APPLY = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [TICK_W-1:0]   event_tick;
		logic [HANDLE_W-1:0] event_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [HANDLE_W-1:0]    found_handle;
		logic [TICK_W-1:0]      head_tick;
		logic [HANDLE_W-1:0]    head_handle;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   is_empty;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic apply;
	} cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/teoq_ctrl.sv
// Controller for the tick-ordered event queue: capture and apply sequencing.
// Depends on teoq_pkg; drives commands to teoq_cells.
`default_nettype none
module teoq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output teoq_pkg::cmd_t     cmd
);

	teoq_pkg::ctrl_state_t state_q, state_d;
	logic rsp_valid_q;
	logic out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= teoq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		out_free    = !rsp_valid_q || !rsp_stall;
		state_d     = state_q;
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.apply   = 1'b0;
		case (state_q)
			teoq_pkg::S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
				if (req_valid) state_d = teoq_pkg::S_APPLY;
			end
			teoq_pkg::S_APPLY: begin
				cmd.apply = out_free;
				if (out_free) state_d = teoq_pkg::S_IDLE;
			end
			default: state_d = teoq_pkg::S_IDLE;
		endcase
	end

	// hold result valid until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_accept_then_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == teoq_pkg::S_APPLY))
		else $error("accepted request did not move to apply");
	a_apply_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> rsp_valid)
		else $error("apply did not raise result valid");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> !cmd.apply)
		else $error("result overwritten while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == teoq_pkg::S_APPLY) |-> req_stall)
		else $error("request accepted while busy");

endmodule
`default_nettype wire

FILE: hw/rtl/teoq_cells.sv
// Datapath: a row of sorted compare-and-shift cells plus the result register.
// Depends on teoq_pkg; commanded by teoq_ctrl.
`default_nettype none
module teoq_cells #(
	parameter int DEPTH = teoq_pkg::DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire teoq_pkg::cmd_t cmd,
	input  wire teoq_pkg::req_t req,
	output teoq_pkg::rsp_t      rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVL   = $clog2(DEPTH);

	logic [teoq_pkg::TICK_W-1:0]   tick_q   [DEPTH];
	logic [teoq_pkg::HANDLE_W-1:0] handle_q [DEPTH];
	logic [CNT_W-1:0]              count_q;

	logic [1:0]                    req_type_s1;
	logic [teoq_pkg::TICK_W-1:0]   tick_s1;
	logic [teoq_pkg::HANDLE_W-1:0] handle_s1;
	logic [DEPTH-1:0]              le_s1, eq_s1, hm_s1;
	logic                          full_s1;

	logic [DEPTH-1:0] le_c, eq_c, hm_c;
	logic [DEPTH-1:0] le_prev, take_new, eq_first, pre;
	logic [teoq_pkg::HANDLE_W-1:0] found;
	logic [teoq_pkg::TICK_W-1:0]   nt [DEPTH];
	logic [teoq_pkg::HANDLE_W-1:0] nh [DEPTH];
	logic [CNT_W-1:0]              ncount;
	logic [1:0]                    nstatus;
	logic [teoq_pkg::HANDLE_W-1:0] nfound;
	teoq_pkg::rsp_t                rsp_q;

	// compare every cell against the incoming request
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			le_c[i] = (CNT_W'(i) < count_q) && (tick_q[i] <= req.event_tick);
			eq_c[i] = (CNT_W'(i) < count_q) && (tick_q[i] == req.event_tick);
			hm_c[i] = (CNT_W'(i) < count_q) && (handle_q[i] == req.event_handle);
		end
	end

	// capture request and cell flags
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_s1 <= req.req_type;
			tick_s1     <= req.event_tick;
			handle_s1   <= req.event_handle;
			le_s1       <= le_c;
			eq_s1       <= eq_c;
			hm_s1       <= hm_c;
			full_s1     <= (count_q == CNT_W'(DEPTH));
		end
	end

	// locate insert slot, first tick match and removal span
	always_comb begin
		le_prev  = {le_s1[DEPTH-2:0], 1'b1};
		take_new = ~le_s1 & le_prev;
		eq_first = eq_s1 & ~{eq_s1[DEPTH-2:0], 1'b0};
		pre      = hm_s1;
		for (int k = 0; k < LVL; k++) begin
			pre = pre | (pre << (1 << k));
		end
		found = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq_first[i]) found = found | handle_q[i];
		end
	end

	// next cell contents
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			nt[i] = tick_q[i];
			nh[i] = handle_q[i];
		end
		ncount  = count_q;
		nstatus = teoq_pkg::ST_OK;
		nfound  = '0;
		case (teoq_pkg::req_code_t'(req_type_s1))
			teoq_pkg::REQ_INSERT: begin
				if (full_s1) begin
					nstatus = teoq_pkg::ST_FULL;
				end else begin
					for (int i = 1; i < DEPTH; i++) begin
						if (!le_prev[i]) begin
							nt[i] = tick_q[i-1];
							nh[i] = handle_q[i-1];
						end
					end
					for (int i = 0; i < DEPTH; i++) begin
						if (take_new[i]) begin
							nt[i] = tick_s1;
							nh[i] = handle_s1;
						end
					end
					ncount = count_q + CNT_W'(1);
				end
			end
			teoq_pkg::REQ_REMOVE: begin
				if (hm_s1 == '0) begin
					nstatus = teoq_pkg::ST_MISS;
				end else begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (pre[i]) begin
							nt[i] = tick_q[i+1];
							nh[i] = handle_q[i+1];
						end
					end
					ncount = count_q - CNT_W'(1);
				end
			end
			teoq_pkg::REQ_LOOKUP: begin
				if (eq_s1 == '0) nstatus = teoq_pkg::ST_MISS;
				else nfound = found;
			end
			default: nstatus = teoq_pkg::ST_OK;
		endcase
	end

	// advance cells on apply
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < DEPTH; i++) begin
				tick_q[i]   <= nt[i];
				handle_q[i] <= nh[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			count_q <= ncount;
		end
	end

	// load result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			rsp_q.status       <= nstatus;
			rsp_q.found_handle <= nfound;
			rsp_q.head_tick    <= (ncount != '0) ? nt[0] : '0;
			rsp_q.head_handle  <= (ncount != '0) ? nh[0] : '0;
			rsp_q.entry_count  <= teoq_pkg::COUNT_OUT_W'(ncount);
			rsp_q.is_empty     <= (ncount == '0);
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tick_ordered_event_queue.sv
// Top level of the tick-ordered event queue: controller plus cell datapath.
// Depends on teoq_pkg, teoq_ctrl and teoq_cells.
//
// Holds up to DEPTH events (tick, handle) sorted by ascending tick, equal ticks
// in arrival order. Each request (insert, remove by handle, lookup first at tick)
// yields one result carrying status, found handle and the head, count and empty
// flag after the request. A request is handled in order: it is first captured
// and compared against every cell in parallel, then the cell row shifts and the
// result register loads. A new request is taken only once the last one has been
// applied, and the apply waits while a held result is stalled. The result
// register lets the next request be captured while a result still waits.
`default_nettype none
module tick_ordered_event_queue #(
	parameter int DEPTH = teoq_pkg::DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire teoq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output teoq_pkg::rsp_t      rsp
);

	teoq_pkg::cmd_t cmd;

	teoq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	teoq_cells #(.DEPTH(DEPTH)) u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
